// ===== hdl/kbl_pkg.sv =====
package kbl_pkg;

	typedef enum logic [2:0] {
		ACT_SET    = 3'd0,
		ACT_QUERY  = 3'd1,
		ACT_START  = 3'd2,
		ACT_DONE   = 3'd3,
		ACT_REJECT = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_EVAL,
		ST_SDIV,
		ST_REFILL,
		ST_DECIDE,
		ST_TDIV,
		ST_FIN
	} state_t;

	localparam int DIV_NW   = 27;
	localparam int DIV_DW   = 24;
	localparam int W_BITS   = 26;
	localparam int TOK_BITS = 34;

	localparam logic [31:0] CONC_WAIT_MS = 32'd50;
	localparam logic [31:0] WAIT_MAX     = 32'hFFFF_FFFF;
	localparam logic [5:0]  BACKOFF_MAX  = 6'd60;
	localparam logic [5:0]  BACKOFF_MIN  = 6'd1;
	localparam logic [15:0] CNT_MAX      = 16'hFFFF;
	localparam logic [9:0]  MS_PER_S     = 10'd1000;
	localparam logic [11:0] QUICK_MS     = 12'd2000;

	typedef struct packed {
		logic                start;
		logic [DIV_NW-1:0]   num;
		logic [DIV_DW-1:0]   den;
	} div_req_t;

endpackage

// ===== hdl/kbl_if.sv =====
interface kbl_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [3:0]  key_slot;
	logic [47:0] now_ms;
	logic        hi_prio;
	logic [15:0] weight_q8;
	logic [15:0] concurrency_cap;
	logic [23:0] rate_q8;

	modport source (output valid, action, key_slot, now_ms, hi_prio, weight_q8,
		concurrency_cap, rate_q8, input ready);
	modport sink (input valid, action, key_slot, now_ms, hi_prio, weight_q8,
		concurrency_cap, rate_q8, output ready);
endinterface

interface kbl_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] wait_ms;
	logic [5:0]  boff_sec;
	logic        key_known;

	modport source (output valid, wait_ms, boff_sec, key_known, input ready);
	modport sink (input valid, wait_ms, boff_sec, key_known, output ready);
endinterface

// ===== hdl/keyed_token_bucket_limiter_top.sv =====
// Keyed token-bucket rate limiter.
// Requests arrive on the req channel: each transaction names a key slot, an
// action (set limit, query, start, done, rejected response) and the current
// time in milliseconds. Every accepted transaction produces exactly one
// transaction on the rsp channel carrying wait_ms, boff_sec and key_known.
// The per-key state lives in one synchronous RAM, one word per key; each
// transaction reads its word, updates it and writes it back before the next
// transaction is taken, so one request is in work at a time.
// The core passes READ, LOAD and EVAL, then goes to FIN for set limit, done,
// rejected response, unknown actions, unconfigured keys and requests held by
// the concurrency cap or a pause. A query or start passes REFILL and DECIDE
// before FIN; the spacing of a start with a nonzero rate (SDIV) and a token
// wait (TDIV) each take one pass of the 27-step serial divider, and a start
// held by its spacing goes from SDIV straight to FIN. A new request is taken
// the cycle after the result moves to the output register. After reset the
// block sweeps the RAM, one key per cycle, marking every key unconfigured;
// req.ready stays low during the sweep.
// The response sits in an output register: a new request is accepted while it
// waits, and if rsp.ready stays low the next result holds in the core until
// the output register frees up.
module keyed_token_bucket_limiter_top #(
	parameter int NUM_KEYS  = 16,
	parameter int TIME_BITS = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	kbl_req_if.sink          req,
	kbl_rsp_if.source        rsp
);
	localparam int TW = TIME_BITS;
	localparam int AW = NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1;
	localparam int SW = (AW > 4 ? AW : 4) + 1;
	localparam int NX = TW > 48 ? TW : 48;
	localparam int WB = kbl_pkg::W_BITS;
	localparam int TB = kbl_pkg::TOK_BITS;
	localparam int NW = kbl_pkg::DIV_NW;

	typedef struct packed {
		logic          valid;
		logic [15:0]   conc_cap;
		logic [23:0]   rate;
		logic [TB-1:0] tokens;
		logic [TW-1:0] refill_ms;
		logic [TW-1:0] success_ms;
		logic [15:0]   in_flight;
		logic [15:0]   hp_waiting;
		logic [5:0]    backoff;
		logic [TW-1:0] pause_end;
	} entry_t;

	localparam int EW = $bits(entry_t);

	kbl_pkg::state_t st_q, st_d;

	// Request fields held for the transaction in work.
	logic [2:0]    act_q;
	logic [AW-1:0] idx_q;
	logic          sok_q;
	logic [TW-1:0] now_q;
	logic          hp_q;
	logic [15:0]   weight_q;
	logic [15:0]   ccap_q;
	logic [23:0]   rate_in_q;

	logic [WB-1:0] w_q;
	logic [TB-1:0] setcap_q;
	entry_t        ent_q;
	logic          elbig_q;
	logic [9:0]    el_q;
	logic [TW-1:0] ss_q;
	logic [TB-1:0] cap_q;
	logic [TB-1:0] prod_q;
	logic          wr_q;
	logic [31:0]   wait_q;
	logic [5:0]    boff_q;
	logic          known_q;
	logic [AW-1:0] clr_q;

	logic          ovalid_q;
	logic [31:0]   owait_q;
	logic [5:0]    oboff_q;
	logic          oknown_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [EW-1:0] ram_rdata;

	kbl_pkg::div_req_t div_req;
	logic              div_done;
	logic [NW-1:0]     div_quo;

	kbl_ram #(.WIDTH(EW), .DEPTH(NUM_KEYS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	kbl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Request decode.
	logic [NX-1:0] now_x;
	logic [SW-1:0] slot_x;
	assign now_x  = NX'(req.now_ms);
	assign slot_x = SW'(req.key_slot);

	// Values taken from the freshly read word.
	entry_t        rd;
	logic [TW-1:0] el_raw;
	logic [TW-1:0] ss_raw;
	assign rd     = entry_t'(ram_rdata);
	assign el_raw = now_q >= rd.refill_ms ? now_q - rd.refill_ms : '0;
	assign ss_raw = now_q >= rd.success_ms ? now_q - rd.success_ms : '0;

	// Evaluation of the stored word.
	logic          known;
	logic          conc_full;
	logic          paused;
	logic [TW-1:0] pause_rem;
	logic [6:0]    b_dbl;
	logic [5:0]    b_new;
	logic [15:0]   b_ms;
	logic [TW:0]   pend;
	logic [TW-1:0] pause_new;
	assign known     = sok_q && ent_q.valid;
	assign conc_full = ent_q.conc_cap != '0 && ent_q.in_flight >= ent_q.conc_cap;
	assign paused    = now_q < ent_q.pause_end;
	assign pause_rem = ent_q.pause_end - now_q;
	assign b_dbl     = {ent_q.backoff, 1'b0};
	assign b_new     = ss_q < TW'(kbl_pkg::QUICK_MS) ? kbl_pkg::BACKOFF_MIN :
		(b_dbl > 7'(kbl_pkg::BACKOFF_MAX) ? kbl_pkg::BACKOFF_MAX : b_dbl[5:0]);
	assign b_ms      = 16'(b_new) * 16'(kbl_pkg::MS_PER_S);
	assign pend      = (TW+1)'(now_q) + (TW+1)'(b_ms);
	assign pause_new = pend[TW] ? '1 : pend[TW-1:0];

	// Refill and token decisions.
	logic [TB:0]   tok_sum;
	logic [TB-1:0] tok_new;
	logic          tok_ge;
	logic          hpw0;
	logic          start_ok;
	logic          need_wait;
	assign tok_sum  = (TB+1)'(ent_q.tokens) + (TB+1)'(prod_q);
	assign tok_new  = elbig_q ? cap_q : (tok_sum > (TB+1)'(cap_q) ? cap_q : tok_sum[TB-1:0]);
	assign tok_ge   = TB'(w_q) <= ent_q.tokens;
	assign hpw0     = ent_q.hp_waiting == '0;
	assign start_ok = (hp_q || hpw0) && tok_ge;
	always_comb begin
		if (act_q == kbl_pkg::ACT_QUERY) begin
			need_wait = hp_q ? !tok_ge : !(tok_ge && hpw0);
		end else begin
			need_wait = !start_ok;
		end
	end

	logic [NW-1:0] tw_num;
	logic [TW-1:0] quo_x;
	assign tw_num = NW'(w_q) - NW'(ent_q.tokens[WB-1:0]) + NW'(ent_q.rate) - NW'(1);
	assign quo_x  = TW'(div_quo);

	logic out_free;
	assign out_free = !ovalid_q || rsp.ready;

	// Next state and strobes.
	always_comb begin
		st_d      = st_q;
		req.ready = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ent_q;
		div_req   = '{start: 1'b0, num: NW'(w_q), den: ent_q.rate};
		unique case (st_q)
			kbl_pkg::ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(NUM_KEYS - 1)) begin
					st_d = kbl_pkg::ST_IDLE;
				end
			end
			kbl_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					st_d = kbl_pkg::ST_READ;
				end
			end
			kbl_pkg::ST_READ: begin
				ram_re = 1'b1;
				st_d   = kbl_pkg::ST_LOAD;
			end
			kbl_pkg::ST_LOAD: begin
				st_d = kbl_pkg::ST_EVAL;
			end
			kbl_pkg::ST_EVAL: begin
				st_d = kbl_pkg::ST_FIN;
				if (known && (act_q == kbl_pkg::ACT_QUERY || act_q == kbl_pkg::ACT_START)
						&& !conc_full && !paused) begin
					if (act_q == kbl_pkg::ACT_START && ent_q.rate != '0) begin
						div_req.start = 1'b1;
						st_d          = kbl_pkg::ST_SDIV;
					end else begin
						st_d = kbl_pkg::ST_REFILL;
					end
				end
			end
			kbl_pkg::ST_SDIV: begin
				if (div_done) begin
					st_d = ss_q < quo_x ? kbl_pkg::ST_FIN : kbl_pkg::ST_REFILL;
				end
			end
			kbl_pkg::ST_REFILL: begin
				st_d = kbl_pkg::ST_DECIDE;
			end
			kbl_pkg::ST_DECIDE: begin
				st_d = kbl_pkg::ST_FIN;
				if (need_wait && !tok_ge && ent_q.rate != '0) begin
					div_req.start = 1'b1;
					div_req.num   = tw_num;
					st_d          = kbl_pkg::ST_TDIV;
				end
			end
			kbl_pkg::ST_TDIV: begin
				if (div_done) begin
					st_d = kbl_pkg::ST_FIN;
				end
			end
			kbl_pkg::ST_FIN: begin
				if (out_free) begin
					ram_we = wr_q;
					st_d   = kbl_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = kbl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= kbl_pkg::ST_CLR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == kbl_pkg::ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (st_q == kbl_pkg::ST_FIN && out_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (st_q == kbl_pkg::ST_FIN && out_free) begin
			owait_q  <= wait_q;
			oboff_q  <= boff_q;
			oknown_q <= known_q;
		end
		unique case (st_q)
			kbl_pkg::ST_IDLE: begin
				act_q     <= req.action;
				idx_q     <= slot_x[AW-1:0];
				sok_q     <= slot_x < SW'(NUM_KEYS);
				now_q     <= now_x[TW-1:0];
				hp_q      <= req.hi_prio;
				weight_q  <= req.weight_q8;
				ccap_q    <= req.concurrency_cap;
				rate_in_q <= req.rate_q8;
				wr_q      <= 1'b0;
				wait_q    <= '0;
				boff_q    <= '0;
				known_q   <= 1'b0;
			end
			kbl_pkg::ST_READ: begin
				w_q      <= WB'(weight_q) * WB'(kbl_pkg::MS_PER_S);
				setcap_q <= TB'(rate_in_q) * TB'(kbl_pkg::MS_PER_S);
			end
			kbl_pkg::ST_LOAD: begin
				ent_q   <= rd;
				elbig_q <= el_raw >= TW'(kbl_pkg::MS_PER_S);
				el_q    <= el_raw[9:0];
				ss_q    <= ss_raw;
			end
			kbl_pkg::ST_EVAL: begin
				cap_q  <= TB'(ent_q.rate) * TB'(kbl_pkg::MS_PER_S);
				prod_q <= TB'(el_q) * TB'(ent_q.rate);
				if (act_q == kbl_pkg::ACT_SET) begin
					if (sok_q) begin
						// A repeated set keeps the in-flight and waiting counts.
						ent_q.valid      <= 1'b1;
						ent_q.conc_cap   <= ccap_q;
						ent_q.rate       <= rate_in_q;
						ent_q.tokens     <= setcap_q;
						ent_q.refill_ms  <= now_q;
						ent_q.success_ms <= now_q;
						ent_q.in_flight  <= ent_q.valid ? ent_q.in_flight : '0;
						ent_q.hp_waiting <= ent_q.valid ? ent_q.hp_waiting : '0;
						ent_q.backoff    <= kbl_pkg::BACKOFF_MIN;
						ent_q.pause_end  <= '0;
						wr_q             <= 1'b1;
						known_q          <= 1'b1;
					end
				end else if (known) begin
					known_q <= 1'b1;
					unique case (act_q)
						kbl_pkg::ACT_QUERY, kbl_pkg::ACT_START: begin
							if (conc_full) begin
								wait_q <= kbl_pkg::CONC_WAIT_MS;
							end else if (paused) begin
								wait_q <= pause_rem > TW'(kbl_pkg::WAIT_MAX) ?
									kbl_pkg::WAIT_MAX : pause_rem[31:0];
							end
						end
						kbl_pkg::ACT_DONE: begin
							if (ent_q.in_flight != '0) begin
								ent_q.in_flight <= ent_q.in_flight - 1'b1;
							end
							ent_q.backoff <= kbl_pkg::BACKOFF_MIN;
							wr_q          <= 1'b1;
						end
						kbl_pkg::ACT_REJECT: begin
							if (ent_q.in_flight != '0) begin
								ent_q.in_flight <= ent_q.in_flight - 1'b1;
							end
							if (!paused) begin
								ent_q.backoff   <= b_new;
								ent_q.pause_end <= pause_new;
								boff_q          <= b_new;
							end else begin
								boff_q <= ent_q.backoff;
							end
							wr_q <= 1'b1;
						end
						default: begin
							wr_q <= 1'b0;
						end
					endcase
				end
			end
			kbl_pkg::ST_SDIV: begin
				if (div_done && ss_q < quo_x) begin
					wait_q <= 32'(quo_x - ss_q);
				end
			end
			kbl_pkg::ST_REFILL: begin
				ent_q.tokens    <= tok_new;
				ent_q.refill_ms <= now_q;
				wr_q            <= 1'b1;
			end
			kbl_pkg::ST_DECIDE: begin
				if (act_q == kbl_pkg::ACT_QUERY) begin
					if (hp_q && !tok_ge && ent_q.hp_waiting != kbl_pkg::CNT_MAX) begin
						ent_q.hp_waiting <= ent_q.hp_waiting + 1'b1;
					end
				end else if (start_ok) begin
					ent_q.tokens     <= ent_q.tokens - TB'(w_q);
					ent_q.success_ms <= now_q;
					if (ent_q.in_flight != kbl_pkg::CNT_MAX) begin
						ent_q.in_flight <= ent_q.in_flight + 1'b1;
					end
					if (hp_q && !hpw0) begin
						ent_q.hp_waiting <= ent_q.hp_waiting - 1'b1;
					end
				end
				if (need_wait) begin
					if (tok_ge) begin
						// Enough tokens, but held back for high-priority waiters.
						wait_q <= 32'd1;
					end else if (ent_q.rate == '0) begin
						wait_q <= kbl_pkg::WAIT_MAX;
					end
				end
			end
			kbl_pkg::ST_TDIV: begin
				if (div_done) begin
					wait_q <= 32'(div_quo);
				end
			end
			default: begin
				wr_q <= wr_q;
			end
		endcase
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.wait_ms   = owait_q;
	assign rsp.boff_sec  = oboff_q;
	assign rsp.key_known = oknown_q;
endmodule

// ===== hdl/kbl_ram.sv =====
module kbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/kbl_div.sv =====
// Restoring divider, one quotient bit per cycle.
module kbl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kbl_pkg::div_req_t             req,
	output logic                          done,
	output logic [kbl_pkg::DIV_NW-1:0]    quo
);
	localparam int NW = kbl_pkg::DIV_NW;
	localparam int DW = kbl_pkg::DIV_DW;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== hdl/kbl_checker.sv =====
module kbl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] wait_ms,
	input logic [5:0]  boff_sec,
	input logic        key_known
);
	// An unknown key reports nothing else.
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !key_known |-> wait_ms == '0 && boff_sec == '0)
		else $error("unknown key with nonzero result");

	a_backoff_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> boff_sec <= kbl_pkg::BACKOFF_MAX)
		else $error("backoff above limit");

	// A backoff comes only from a rejected response, which never asks to wait.
	a_backoff_nowait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && boff_sec != '0 |-> wait_ms == '0 && key_known)
		else $error("backoff together with wait");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(wait_ms)
			&& $stable(boff_sec) && $stable(key_known))
		else $error("response dropped or changed while stalled");
endmodule

bind keyed_token_bucket_limiter_top kbl_checker u_kbl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.wait_ms   (rsp.wait_ms),
	.boff_sec  (rsp.boff_sec),
	.key_known (rsp.key_known)
);
